### rtl/rtm_pkg.sv
// Shared types, codes and helpers for the row-by-matrix product block.
package rtm_pkg;

	localparam int unsigned IDX_W      = 6;
	localparam int unsigned LEN_W      = 7;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned INDEX_SPAN = 64;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [DATA_W-1:0] word_t;

	typedef enum logic {
		OP_LOAD_B = 1'b0,
		OP_ROW_A  = 1'b1
	} opcode_t;

	typedef enum logic {
		REG_INNER_LENGTH = 1'b0,
		REG_OUT_COLUMNS  = 1'b1
	} reg_index_t;

	// Tag that travels alongside one multiply-accumulate beat.
	typedef struct packed {
		logic valid;
		logic first;
		logic last;
		logic last_row;
		idx_t col;
	} beat_tag_t;

	// Zero counts as one, anything above the limit saturates.
	function automatic len_t clamp_len(input len_t v, input len_t top);
		len_t r;
		r = v;
		if (v == '0) begin
			r = len_t'(1);
		end else if (v > top) begin
			r = top;
		end
		return r;
	endfunction

endpackage

### rtl/row_times_matrix_int32_core.sv
// Top level: signed 32-bit row-by-matrix product over one shared MAC.
//
// Usage:
//  - Input beats use start/busy: a beat is taken at a clock edge with start high and
//    busy low. opcode OP_LOAD_B writes B word (column_index, inner_index);
//    OP_ROW_A writes the A element at inner_index. Indices past the stores are dropped.
//  - A load beat, or an A element that does not close the row, leaves busy low.
//  - The A element at index inner_length-1 closes the row: busy rises and the
//    shared MAC runs inner_length * out_columns beats, one per cycle, walking
//    inner index fastest. Each beat passes the registered RAM read, the
//    product register and the result register; busy drops in the same cycle
//    that the row's last result strobes.
//  - Results: result_valid strobes for one cycle per output column, with
//    result_column, product_sum and last_of_row.
//    The receiver cannot stall: it must take each beat as it appears.
//  - Configuration: cfg_we/cfg_index/cfg_wdata write inner_length or
//    out_columns; write only while busy is low.
//  - Reset clears control and restores both lengths to 64. The B and A
//    stores are not cleared; read only entries that were written.
module row_times_matrix_int32_core #(
	parameter int unsigned MAX_INNER   = 64,
	parameter int unsigned MAX_COLUMNS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  rtm_pkg::idx_t       inner_index,
	input  rtm_pkg::idx_t       column_index,
	input  logic signed [31:0]  element_value,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  rtm_pkg::len_t       cfg_wdata,
	output logic                result_valid,
	output rtm_pkg::idx_t       result_column,
	output logic signed [31:0]  product_sum,
	output logic                last_of_row
);

	// The inner index port spans 64 positions, so the A row never needs more.
	localparam int unsigned ISPAN  = (MAX_INNER < rtm_pkg::INDEX_SPAN) ?
	                                 MAX_INNER : rtm_pkg::INDEX_SPAN;
	localparam int unsigned KW     = (ISPAN > 1) ? $clog2(ISPAN) : 1;
	localparam int unsigned CW     = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
	localparam int unsigned BDEPTH = MAX_COLUMNS * ISPAN;
	localparam int unsigned BAW    = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;

	rtm_pkg::len_t      inner_length_q;
	rtm_pkg::len_t      out_columns_q;
	rtm_pkg::len_t      n_in;
	rtm_pkg::len_t      n_out;
	logic               accept;
	logic               k_ok;
	logic               col_ok;
	logic               b_we;
	logic               a_we;
	logic               fire;
	logic [BAW-1:0]     b_waddr;
	logic [BAW-1:0]     b_raddr;
	logic [KW-1:0]      a_raddr;
	rtm_pkg::word_t     a_rdata;
	rtm_pkg::word_t     b_rdata;
	rtm_pkg::word_t     sum_word;
	rtm_pkg::beat_tag_t tag;
	logic               issuing;
	logic               pipe_busy;

	// Configuration registers; only the two listed indexes exist.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inner_length_q <= rtm_pkg::len_t'(64);
			out_columns_q  <= rtm_pkg::len_t'(64);
		end else if (cfg_we) begin
			case (rtm_pkg::reg_index_t'(cfg_index))
				rtm_pkg::REG_INNER_LENGTH: inner_length_q <= cfg_wdata;
				rtm_pkg::REG_OUT_COLUMNS:  out_columns_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	assign n_in  = rtm_pkg::clamp_len(inner_length_q, rtm_pkg::len_t'(ISPAN));
	assign n_out = rtm_pkg::clamp_len(out_columns_q, rtm_pkg::len_t'(MAX_COLUMNS));

	// Input beat decode: drop indices that fall outside the stores.
	assign accept = start && !busy;
	assign k_ok   = ({1'b0, inner_index} < rtm_pkg::len_t'(ISPAN));
	assign col_ok = ({1'b0, column_index} < rtm_pkg::len_t'(MAX_COLUMNS));
	assign b_we   = accept && (rtm_pkg::opcode_t'(opcode) == rtm_pkg::OP_LOAD_B) &&
	                k_ok && col_ok;
	assign a_we   = accept && (rtm_pkg::opcode_t'(opcode) == rtm_pkg::OP_ROW_A) && k_ok;
	assign fire   = a_we && ({1'b0, inner_index} == (n_in - rtm_pkg::len_t'(1)));

	// B is stored transposed: each column's weights sit in one contiguous run.
	assign b_waddr = BAW'(BAW'(column_index[CW-1:0]) * BAW'(ISPAN)) +
	                 BAW'(inner_index[KW-1:0]);

	rtm_ram #(
		.WIDTH(rtm_pkg::DATA_W),
		.DEPTH(BDEPTH)
	) u_b_ram (
		.clk  (clk),
		.we   (b_we),
		.waddr(b_waddr),
		.wdata(element_value),
		.raddr(b_raddr),
		.rdata(b_rdata)
	);

	rtm_ram #(
		.WIDTH(rtm_pkg::DATA_W),
		.DEPTH(ISPAN)
	) u_a_ram (
		.clk  (clk),
		.we   (a_we),
		.waddr(inner_index[KW-1:0]),
		.wdata(element_value),
		.raddr(a_raddr),
		.rdata(a_rdata)
	);

	// Advance one (column, inner index) beat per cycle once the row closes.
	rtm_seq #(
		.ISPAN(ISPAN),
		.NCOLS(MAX_COLUMNS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.n_in   (n_in),
		.n_out  (n_out),
		.issuing(issuing),
		.a_raddr(a_raddr),
		.b_raddr(b_raddr),
		.tag    (tag)
	);

	rtm_mac u_mac (
		.clk          (clk),
		.arst_n       (arst_n),
		.tag          (tag),
		.a_rdata      (a_rdata),
		.b_rdata      (b_rdata),
		.pipe_busy    (pipe_busy),
		.result_valid (result_valid),
		.result_column(result_column),
		.product_sum  (sum_word),
		.last_of_row  (last_of_row)
	);

	assign product_sum = sum_word;

	// Hold off input beats until the last MAC beat has left the pipe.
	assign busy = issuing || pipe_busy;

endmodule

### rtl/rtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rtm_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/rtm_seq.sv
// Sequencer: walks inner index and output column, issuing one MAC beat per cycle.
module rtm_seq #(
	parameter int unsigned ISPAN = 64,
	parameter int unsigned NCOLS = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  fire,
	input  rtm_pkg::len_t         n_in,
	input  rtm_pkg::len_t         n_out,
	output logic                  issuing,
	output logic [((ISPAN > 1) ? $clog2(ISPAN) : 1)-1:0] a_raddr,
	output logic [((NCOLS * ISPAN > 1) ? $clog2(NCOLS * ISPAN) : 1)-1:0] b_raddr,
	output rtm_pkg::beat_tag_t    tag
);

	localparam int unsigned KW  = (ISPAN > 1) ? $clog2(ISPAN) : 1;
	localparam int unsigned CW  = (NCOLS > 1) ? $clog2(NCOLS) : 1;
	localparam int unsigned BAW = (NCOLS * ISPAN > 1) ? $clog2(NCOLS * ISPAN) : 1;

	typedef enum logic {
		S_IDLE,
		S_RUN
	} state_t;

	state_t         state_q;
	logic [KW-1:0]  j_q;
	logic [KW-1:0]  jlast_q;
	logic [CW-1:0]  c_q;
	logic [CW-1:0]  clast_q;
	logic [BAW-1:0] base_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			j_q     <= '0;
			jlast_q <= '0;
			c_q     <= '0;
			clast_q <= '0;
			base_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (fire) begin
						state_q <= S_RUN;
						j_q     <= '0;
						c_q     <= '0;
						base_q  <= '0;
						jlast_q <= KW'(n_in - rtm_pkg::len_t'(1));
						clast_q <= CW'(n_out - rtm_pkg::len_t'(1));
					end
				end
				S_RUN: begin
					if (j_q == jlast_q) begin
						j_q <= '0;
						if (c_q == clast_q) begin
							state_q <= S_IDLE;
						end else begin
							c_q    <= c_q + CW'(1);
							base_q <= base_q + BAW'(ISPAN);
						end
					end else begin
						j_q <= j_q + KW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign issuing      = (state_q == S_RUN);
	assign a_raddr      = j_q;
	assign b_raddr      = base_q + BAW'(j_q);
	assign tag.valid    = issuing;
	assign tag.first    = (j_q == '0);
	assign tag.last     = (j_q == jlast_q);
	assign tag.last_row = (c_q == clast_q);
	assign tag.col      = rtm_pkg::idx_t'(c_q);

endmodule

### rtl/rtm_mac.sv
// Shared multiply-accumulate datapath with registered result outputs.
module rtm_mac (
	input  logic               clk,
	input  logic               arst_n,
	input  rtm_pkg::beat_tag_t tag,
	input  rtm_pkg::word_t     a_rdata,
	input  rtm_pkg::word_t     b_rdata,
	output logic               pipe_busy,
	output logic               result_valid,
	output rtm_pkg::idx_t      result_column,
	output rtm_pkg::word_t     product_sum,
	output logic               last_of_row
);

	rtm_pkg::beat_tag_t tag_s1;
	rtm_pkg::beat_tag_t tag_s2;
	rtm_pkg::word_t     prod_s2;
	rtm_pkg::word_t     acc_q;
	rtm_pkg::word_t     sum;

	// Low half of the product is the same for signed and unsigned operands.
	assign sum = (tag_s2.first ? '0 : acc_q) + prod_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1       <= '0;
			tag_s2       <= '0;
			result_valid <= 1'b0;
		end else begin
			tag_s1       <= tag;
			tag_s2       <= tag_s1;
			result_valid <= tag_s2.valid && tag_s2.last;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= a_rdata * b_rdata;
		if (tag_s2.valid) begin
			acc_q <= sum;
		end
		if (tag_s2.valid && tag_s2.last) begin
			result_column <= tag_s2.col;
			product_sum   <= sum;
			last_of_row   <= tag_s2.last_row;
		end
	end

	assign pipe_busy = tag_s1.valid || tag_s2.valid;

endmodule

### rtl/rtm_checker.sv
// Port-level checker for the row-by-matrix core, bound to the top level.
module rtm_checker (
	input logic clk,
	input logic arst_n,
	input logic busy,
	input logic result_valid,
	input logic last_of_row
);

	// A result beat only follows a cycle of MAC work.
	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result beat without preceding busy cycle");

	// Mid-row results leave more columns in flight.
	a_busy_mid_row: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !last_of_row) |-> busy)
		else $error("block idle before the row finished");

	// The row's final beat drains the block completely.
	a_idle_at_row_end: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_row) |-> !busy)
		else $error("still busy on the last beat of a row");

	// No result beat follows the final beat of a row directly.
	a_quiet_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_of_row) |=> !result_valid)
		else $error("result beat right after the last of a row");

endmodule

bind row_times_matrix_int32_core rtm_checker u_rtm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.busy        (busy),
	.result_valid(result_valid),
	.last_of_row (last_of_row)
);
